>>> hdl/sha256md_pkg.sv
`default_nettype none

package sha256md_pkg;

    typedef logic [31:0] t_word;
    typedef logic [7:0][31:0] t_hash;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic       push;
        logic [7:0] push_byte;
        logic       init_vars;
        logic       round;
        logic       add;
        logic       reinit;
    } t_core_ctl;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [7:0] PAD_ZERO = 8'h00;
    localparam logic [5:0] FILL_LEN_POS = 6'd56;
    localparam logic [5:0] FILL_LAST = 6'd63;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [2:0] LEN_LAST = 3'd7;
    localparam logic [2:0] WORD_LAST = 3'd7;

    localparam t_hash H_INIT = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam t_word K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word ror(input t_word x, input int n);
        logic [63:0] tmp;
        tmp = {x, x} >> n;
        return tmp[31:0];
    endfunction

    function automatic t_word sml_sig0(input t_word x);
        return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word sml_sig1(input t_word x);
        return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word big_sig0(input t_word x);
        return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic t_word big_sig1(input t_word x);
        return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

endpackage

`default_nettype wire

>>> hdl/sha256_message_digest.sv
// Input: one byte item per cycle while idle; input is stalled while each full 64-byte block
// runs 64 rounds on the single round unit and then the hash update.
// Closing item: padding bytes and 8 length bytes are pushed, filling one or two blocks,
// then 8 digest items, one per cycle while the sink is ready.
// The byte-wide load path and the round unit do not overlap: no bytes are taken during rounds.
// Reset (synchronous, active low): initial hash values, empty message, idle.
`default_nettype none

module sha256_message_digest (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire [0:0]  s_axis_tuser,   // [0] byte_valid
    input  wire        s_axis_tlast,   // end_of_message
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [31:0] digest_word
    output logic [2:0] m_axis_tuser,   // [2:0] word_index
    output logic       m_axis_tlast    // last_word
);
    import sha256md_pkg::*;

    t_state    r_state;
    t_state    n_state;
    logic [5:0]  r_fill;
    logic [60:0] r_count;
    logic        r_pad80;
    logic        r_closing;
    logic        r_lastblk;
    logic [63:0] r_len;
    logic [2:0]  r_lencnt;
    logic [5:0]  r_rnd;
    logic [2:0]  r_oidx;

    t_core_ctl ctl;
    t_hash     hash;
    logic      in_acc;
    logic      out_acc;
    logic      pad_done;

    sha256md_comp u_comp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_rnd   (r_rnd),
        .o_hash  (hash)
    );

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_acc  = m_axis_tvalid && m_axis_tready;
    assign pad_done = !r_pad80 && (r_fill == FILL_LEN_POS);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tuser[0] && (r_fill == FILL_LAST)) begin
                        n_state = ST_ROUND;
                    end else if (s_axis_tlast) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (pad_done) begin
                    n_state = ST_LEN;
                end else if (r_fill == FILL_LAST) begin
                    n_state = ST_ROUND;
                end
            end
            ST_LEN: begin
                if (r_lencnt == LEN_LAST) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (r_rnd == ROUND_LAST) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                if (r_lastblk) begin
                    n_state = ST_OUT;
                end else if (r_closing) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (out_acc && (r_oidx == WORD_LAST)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        ctl           = '0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                ctl.push      = in_acc && s_axis_tuser[0];
                ctl.push_byte = s_axis_tdata;
            end
            ST_PAD: begin
                ctl.push      = !pad_done;
                ctl.push_byte = r_pad80 ? PAD_MARK : PAD_ZERO;
            end
            ST_LEN: begin
                ctl.push      = 1'b1;
                ctl.push_byte = r_len[63:56];
            end
            ST_ROUND: ctl.round = 1'b1;
            ST_ADD:   ctl.add = 1'b1;
            ST_OUT: begin
                m_axis_tvalid = 1'b1;
                ctl.reinit    = out_acc && (r_oidx == WORD_LAST);
            end
            default: ;
        endcase
        ctl.init_vars = ctl.push && (r_fill == FILL_LAST);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_fill    <= '0;
            r_count   <= '0;
            r_pad80   <= 1'b0;
            r_closing <= 1'b0;
            r_lastblk <= 1'b0;
            r_lencnt  <= '0;
            r_rnd     <= '0;
            r_oidx    <= '0;
        end else begin
            r_state <= n_state;
            if (ctl.push) begin
                r_fill <= r_fill + 6'd1;
            end
            if (ctl.round) begin
                r_rnd <= r_rnd + 6'd1;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_closing <= s_axis_tlast;
                        r_pad80   <= s_axis_tlast;
                        if (s_axis_tuser[0]) begin
                            r_count <= r_count + 61'd1;
                        end
                    end
                end
                ST_PAD: begin
                    r_pad80 <= 1'b0;
                    if (pad_done) begin
                        r_lencnt <= '0;
                    end
                end
                ST_LEN: begin
                    r_lencnt <= r_lencnt + 3'd1;
                    if (r_lencnt == LEN_LAST) begin
                        r_lastblk <= 1'b1;
                    end
                end
                ST_ADD: begin
                    r_oidx <= '0;
                end
                ST_OUT: begin
                    if (out_acc) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == WORD_LAST) begin
                            r_count   <= '0;
                            r_closing <= 1'b0;
                            r_lastblk <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // bit length, shifted out most significant byte first
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_PAD) && pad_done) begin
            r_len <= {r_count, 3'b000};
        end else if (r_state == ST_LEN) begin
            r_len <= {r_len[55:0], 8'h00};
        end
    end

    assign m_axis_tdata = hash[r_oidx];
    assign m_axis_tuser = r_oidx;
    assign m_axis_tlast = (r_oidx == WORD_LAST);

endmodule

`default_nettype wire

>>> hdl/sha256md_comp.sv
`default_nettype none

module sha256md_comp (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire sha256md_pkg::t_core_ctl i_ctl,
    input  wire [5:0]               i_rnd,
    output sha256md_pkg::t_hash     o_hash
);
    import sha256md_pkg::*;

    t_word r_w [16];
    t_word r_v [8];
    t_hash r_h;

    t_word w_new;
    t_word wt;
    t_word t1;
    t_word t2;
    t_word ch;
    t_word mj;

    always_comb begin
        w_new = r_w[0] + sml_sig0(r_w[1]) + r_w[9] + sml_sig1(r_w[14]);
        wt    = (i_rnd[5:4] == 2'b00) ? r_w[0] : w_new;
        ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        mj    = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1    = r_v[7] + big_sig1(r_v[4]) + ch + K_ROUND[i_rnd] + wt;
        t2    = big_sig0(r_v[0]) + mj;
    end

    // message window: bytes shift in big-endian, words shift during rounds
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= {r_w[i][23:0], r_w[i+1][31:24]};
            end
            r_w[15] <= {r_w[15][23:0], i_ctl.push_byte};
        end else if (i_ctl.round) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= wt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.init_vars) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_h[i];
            end
        end else if (i_ctl.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h <= H_INIT;
        end else if (i_ctl.reinit) begin
            r_h <= H_INIT;
        end else if (i_ctl.add) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= r_h[i] + r_v[i];
            end
        end
    end

    assign o_hash = r_h;

endmodule

`default_nettype wire
